### rtl/mbq_pkg.sv
// Shared constants and types of the multichannel biquad IIR.
// Used by the serial multiplier lane and the top level; no dependencies.
package mbq_pkg;

  // Default values of the top-level parameters
  localparam int unsigned DEF_MAX_CHANNELS   = 8;
  localparam int unsigned DEF_SAMPLE_BITS    = 24;
  localparam int unsigned DEF_COEF_FRAC_BITS = 28;

  // Fixed formats
  localparam int unsigned COEF_BITS    = 32;
  localparam int unsigned DELAY_BITS   = 48;
  localparam int unsigned PROD_SHIFT   = 11;
  localparam int unsigned CH_CFG_BITS  = 4;
  localparam int unsigned OUT_CH_BITS  = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0       = 3'd0,
    REG_B1       = 3'd1,
    REG_B2       = 3'd2,
    REG_A1       = 3'd3,
    REG_A2       = 3'd4,
    REG_CHANNELS = 3'd5
  } cfg_idx_e;

endpackage

### rtl/mbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbq_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mbq_serial_mul.sv
// Bit-serial signed multiplier lane: one multiplier bit per cycle, shift-add.
// Depends on mbq_pkg (coefficient width).
module mbq_serial_mul #(
  parameter int unsigned MPLIER_BITS = 24
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [mbq_pkg::COEF_BITS-1:0]              mcand_i,
  input  logic [MPLIER_BITS-1:0]                     mplier_i,
  output logic                                       last_o,
  output logic [mbq_pkg::COEF_BITS+MPLIER_BITS:0]    product_o
);
  import mbq_pkg::*;

  localparam int unsigned CNT_W = $clog2(MPLIER_BITS);

  logic                      busy_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [COEF_BITS:0]        hi_q;
  logic [MPLIER_BITS-1:0]    lo_q;
  logic signed [COEF_BITS+1:0] hi_ext;
  logic signed [COEF_BITS+1:0] mc_ext;
  logic signed [COEF_BITS+1:0] sum;
  logic                      last;

  assign last   = busy_q && (cnt_q == CNT_W'(MPLIER_BITS - 1));
  assign hi_ext = {hi_q[COEF_BITS], hi_q};
  assign mc_ext = {{2{mcand_i[COEF_BITS-1]}}, mcand_i};

  // The sign bit of the multiplier carries negative weight: subtract there.
  always_comb begin
    if (!lo_q[0]) begin
      sum = hi_ext;
    end else if (last) begin
      sum = hi_ext - mc_ext;
    end else begin
      sum = hi_ext + mc_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[COEF_BITS+1:1];
      lo_q <= {sum[0], lo_q[MPLIER_BITS-1:1]};
    end
  end

  assign last_o    = last;
  assign product_o = {hi_q, lo_q};

endmodule

### rtl/multichannel_biquad_iir.sv
// Top level of the multichannel biquad IIR filter (transposed direct form II).
// Depends on mbq_pkg, mbq_serial_mul and mbq_ram.

// Interleaved samples enter on the slave stream, one at a time, and are
// assigned to channels by an internal counter that wraps at the configured
// channel count. Every sample runs through one second-order section with a
// shared coefficient set (Q3.28): y = b0*x + z1, z1' = b1*x - a1*y + z2,
// z2' = b2*x - a2*y. Products are rounded to the 48-bit delay format, y is
// rounded and saturated to the sample width, delay words saturate to 48 bits.
// The multiplies run on three bit-serial lanes; the feed-forward products
// and the feedback products are two passes over those lanes, so a new
// sample is accepted only after the previous one has been written back.
// The input is accepted again while the finished result waits in the
// output register. A clear opcode (tuser high) zeroes all delay lines and
// the channel counter and gives no result; writing the channel-count
// register does the same.
// The delay words of all channels sit in one RAM; a valid bit per channel
// makes a cleared channel read as zero, so no clearing pass is needed.
// The configuration port is always ready; write it only while idle.
module multichannel_biquad_iir #(
  parameter int unsigned MAX_CHANNELS   = mbq_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned SAMPLE_BITS    = mbq_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = mbq_pkg::DEF_COEF_FRAC_BITS,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SAMPLE_BITS + mbq_pkg::OUT_CH_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,  // in_sample, zero pad
  input  logic                              s_axis_tuser,  // opcode
  input  logic                              s_axis_tlast,  // block_end
  // Master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata,  // out_sample, out_channel, zero pad
  output logic                              m_axis_tlast,  // out_block_end
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbq_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [mbq_pkg::COEF_BITS-1:0]     cfg_data_i
);
  import mbq_pkg::*;

  localparam int unsigned CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CMP_W     = 8;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PW        = COEF_BITS + SAMPLE_BITS + 1;  // lane product
  localparam int unsigned MW        = PW + 1 - PROD_SHIFT;          // rounded product
  localparam int unsigned AW        = ((MW > DELAY_BITS) ? MW : DELAY_BITS) + 2;
  localparam int unsigned OUT_SHIFT = COEF_FRAC_BITS - PROD_SHIFT;
  localparam int unsigned YW        = AW + 1 - OUT_SHIFT;
  localparam int unsigned RAM_W     = 2 * DELAY_BITS;
  localparam int unsigned MUL_LAT   = SAMPLE_BITS + 1;

  localparam logic [PW:0] P_RND = (PW + 1)'(1) << (PROD_SHIFT - 1);
  localparam logic [AW:0] Y_RND = (AW + 1)'(1) << (OUT_SHIFT - 1);
  localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MULX = 9'b000000010,
    ST_RNDX = 9'b000000100,
    ST_ACC  = 9'b000001000,
    ST_OUT  = 9'b000010000,
    ST_MULY = 9'b000100000,
    ST_RNDY = 9'b001000000,
    ST_DIFF = 9'b010000000,
    ST_WB   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [CH_CFG_BITS-1:0] chans_q;

  // Channel bookkeeping
  logic [CH_W-1:0]         cnt_q;
  logic [CH_W-1:0]         ch_q;
  logic [CH_W-1:0]         ch_sel;
  logic [MAX_CHANNELS-1:0] valid_q;
  logic [CMP_W-1:0]        act8, cnt8, nxt8;

  // Handshakes
  logic s_fire, cfg_fire, do_clear, out_free, ram_we;

  // Multiplier lanes
  logic                   lane_start;
  logic                   ff_pass;
  logic [SAMPLE_BITS-1:0] lane_mplier;
  logic [COEF_BITS-1:0]   lane_mcand [NUM_LANES];
  logic [NUM_LANES-1:0]   lane_last;
  logic [PW-1:0]          lane_prod [NUM_LANES];
  logic [PW:0]            prod_rnd [NUM_LANES];
  logic signed [MW-1:0]   prod_r [NUM_LANES];

  // Datapath registers
  logic signed [MW-1:0]          mb0_q, mb1_q, mb2_q, ma1_q, ma2_q;
  logic signed [MW:0]            t1_q, t2_q;
  logic signed [AW-1:0]          acc_q;
  logic signed [SAMPLE_BITS-1:0] y_q, y_d;
  logic                          last_q;

  // Delay words
  logic [RAM_W-1:0]             ram_rdata, ram_wdata;
  logic signed [DELAY_BITS-1:0] d1, d2, z1_sat, z2_sat;
  logic signed [AW-1:0]         z1_w, z2_w;
  logic [AW:0]                  y_rnd;
  logic signed [YW-1:0]         y_full;

  // Output register
  logic                   m_valid_q;
  logic [SAMPLE_BITS-1:0] m_sample_q;
  logic [OUT_CH_BITS-1:0] m_ch_q;
  logic                   m_last_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign ram_we        = (state_q == ST_WB) && out_free;

  assign do_clear = (s_fire && (opcode_e'(s_axis_tuser) == OP_CLEAR))
                 || (cfg_fire && (cfg_idx_e'(cfg_index_i) == REG_CHANNELS));

  // Active channel count: zero acts as one, above the maximum saturates.
  always_comb begin
    if (chans_q == '0) begin
      act8 = CMP_W'(1);
    end else if (CMP_W'(chans_q) > CMP_W'(MAX_CHANNELS)) begin
      act8 = CMP_W'(MAX_CHANNELS);
    end else begin
      act8 = CMP_W'(chans_q);
    end
  end

  assign cnt8   = CMP_W'(cnt_q);
  assign ch_sel = (cnt8 >= act8) ? '0 : cnt_q;
  assign nxt8   = CMP_W'(ch_q) + CMP_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q    <= B0_RESET;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
      chans_q <= CH_CFG_BITS'(1);
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_B0:       b0_q    <= cfg_data_i;
        REG_B1:       b1_q    <= cfg_data_i;
        REG_B2:       b2_q    <= cfg_data_i;
        REG_A1:       a1_q    <= cfg_data_i;
        REG_A2:       a2_q    <= cfg_data_i;
        REG_CHANNELS: chans_q <= cfg_data_i[CH_CFG_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier lanes: feed-forward pass on x, then feedback pass on y
  // ---------------------------------------------------------------------------
  // The lanes read the multiplicand on every step: hold the feed-forward
  // coefficients through the whole first pass.
  assign ff_pass       = state_q inside {ST_IDLE, ST_MULX};
  assign lane_start    = (s_fire && (opcode_e'(s_axis_tuser) == OP_FILTER))
                      || (state_q == ST_OUT);
  assign lane_mplier   = (state_q == ST_IDLE) ? s_axis_tdata[SAMPLE_BITS-1:0] : y_d;
  assign lane_mcand[0] = ff_pass ? b0_q : a1_q;
  assign lane_mcand[1] = ff_pass ? b1_q : a2_q;
  assign lane_mcand[2] = b2_q;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mbq_serial_mul #(
      .MPLIER_BITS (SAMPLE_BITS)
    ) u_mul (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (lane_start),
      .mcand_i   (lane_mcand[g]),
      .mplier_i  (lane_mplier),
      .last_o    (lane_last[g]),
      .product_o (lane_prod[g])
    );
  end

  // Round half up, then floor shift into the delay format.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_rnd[i] = {lane_prod[i][PW-1], lane_prod[i]} + P_RND;
      prod_r[i]   = prod_rnd[i][PW:PROD_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // Delay RAM: {z2, z1} per channel; an entry without its valid bit reads zero
  // ---------------------------------------------------------------------------
  mbq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_CHANNELS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .raddr_i (ch_q),
    .rdata_o (ram_rdata)
  );

  assign d1 = valid_q[ch_q] ? ram_rdata[DELAY_BITS-1:0] : '0;
  assign d2 = valid_q[ch_q] ? ram_rdata[RAM_W-1:DELAY_BITS] : '0;

  // Output: round by OUT_SHIFT, saturate to the sample range.
  assign y_rnd  = {acc_q[AW-1], acc_q} + Y_RND;
  assign y_full = y_rnd[AW:OUT_SHIFT];

  always_comb begin
    if ((y_full[YW-1:SAMPLE_BITS-1] == '0) || (y_full[YW-1:SAMPLE_BITS-1] == '1)) begin
      y_d = y_full[SAMPLE_BITS-1:0];
    end else if (y_full[YW-1]) begin
      y_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // New delay words, saturated to 48 bits.
  assign z1_w = AW'(t1_q) + AW'(d2);
  assign z2_w = AW'(t2_q);

  always_comb begin
    if ((z1_w[AW-1:DELAY_BITS-1] == '0) || (z1_w[AW-1:DELAY_BITS-1] == '1)) begin
      z1_sat = z1_w[DELAY_BITS-1:0];
    end else if (z1_w[AW-1]) begin
      z1_sat = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      z1_sat = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
    if ((z2_w[AW-1:DELAY_BITS-1] == '0) || (z2_w[AW-1:DELAY_BITS-1] == '1)) begin
      z2_sat = z2_w[DELAY_BITS-1:0];
    end else if (z2_w[AW-1]) begin
      z2_sat = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      z2_sat = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  end

  assign ram_wdata = {z2_sat, z1_sat};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && (opcode_e'(s_axis_tuser) == OP_FILTER)) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        if (&lane_last) begin
          state_d = ST_RNDX;
        end
      end
      ST_RNDX: state_d = ST_ACC;
      ST_ACC:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_MULY;
      ST_MULY: begin
        if (&lane_last) begin
          state_d = ST_RNDY;
        end
      end
      ST_RNDY: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_WB;
      ST_WB: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_clear) begin
        cnt_q   <= '0;
        valid_q <= '0;
      end else if (ram_we) begin
        cnt_q          <= (nxt8 >= act8) ? '0 : nxt8[CH_W-1:0];
        valid_q[ch_q]  <= 1'b1;
      end
      if (ram_we) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ch_q   <= ch_sel;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_RNDX) begin
      mb0_q <= prod_r[0];
      mb1_q <= prod_r[1];
      mb2_q <= prod_r[2];
    end
    if (state_q == ST_ACC) begin
      acc_q <= AW'(mb0_q) + AW'(d1);
    end
    if (state_q == ST_OUT) begin
      y_q <= y_d;
    end
    if (state_q == ST_RNDY) begin
      ma1_q <= prod_r[0];
      ma2_q <= prod_r[1];
    end
    if (state_q == ST_DIFF) begin
      t1_q <= (MW + 1)'(mb1_q) - (MW + 1)'(ma1_q);
      t2_q <= (MW + 1)'(mb2_q) - (MW + 1)'(ma2_q);
    end
    if (ram_we) begin
      m_sample_q <= y_q;
      m_ch_q     <= OUT_CH_BITS'(CMP_W'(ch_q));
      m_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_ch_q, m_sample_q});
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The channel counter never reaches the active channel count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt8 < act8)
    else $error("channel counter out of range");

  // A filtered sample finishes its feed-forward multiplies in a fixed time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s_fire && (opcode_e'(s_axis_tuser) == OP_FILTER)) |-> ##MUL_LAT (state_q == ST_RNDX))
    else $error("feed-forward multiply latency mismatch");

  // Every delay write-back comes with a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |=> m_axis_tvalid)
    else $error("write-back without result");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_biquad_iir: streams samples and
// register writes, predicts every filtered sample and compares the outputs.
// Depends on mbq_pkg and the filter RTL only; reads no files.
module testbench;
  import mbq_pkg::*;

  localparam int unsigned NCH          = DEF_MAX_CHANNELS;
  localparam int unsigned SBITS        = DEF_SAMPLE_BITS;
  localparam int unsigned OUT_SHIFT    = DEF_COEF_FRAC_BITS - PROD_SHIFT;
  // Cycles to let the datapath settle before a register write (a full sample
  // time plus margin).
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned MAX_REPORTS  = 10;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

  localparam logic [SBITS-1:0]     SMP_MAX  = 24'h7FFFFF;
  localparam logic [SBITS-1:0]     SMP_MIN  = 24'h800000;
  localparam logic [COEF_BITS-1:0] COEF_MAX = 32'h7FFFFFFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN = 32'h80000000;
  localparam logic [COEF_BITS-1:0] COEF_ONE = 32'h10000000;
  localparam logic [COEF_BITS-1:0] COEF_HALF     = 32'h08000000;
  localparam logic [COEF_BITS-1:0] COEF_NEG_HALF = 32'hF8000000;

  typedef struct packed {
    logic [SBITS-1:0]       sample;
    logic [OUT_CH_BITS-1:0] chan;
    logic                   last;
  } filt_out_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [SBITS-1:0]        s_axis_tdata  = '0;   // in_sample
  logic                    s_axis_tuser  = OP_FILTER;  // opcode
  logic                    s_axis_tlast  = 1'b0;  // block_end
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;  // out_sample, out_channel, zero pad
  logic                    m_axis_tlast;  // out_block_end
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [COEF_BITS-1:0]    cfg_data_i  = '0;

  // Idling percentages of the two stream sides
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned fail_count    = 0;

  // Filter state as the block should hold it
  longint      k_b0, k_b1, k_b2, k_a1, k_a2;
  logic [CH_CFG_BITS-1:0] chan_cfg;
  longint      dly_one [NCH];
  longint      dly_two [NCH];
  int unsigned chan_ptr;

  // Filtered samples still owed by the block, oldest first
  filt_out_t   awaited_outputs[$];

  multichannel_biquad_iir dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Filter prediction
  // ---------------------------------------------------------------------

  // Round half up, then floor shift
  function automatic longint rnd_shift(input longint v, input int unsigned s);
    rnd_shift = (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(input longint v, input int unsigned bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    sat = (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Coefficient times sample, rounded to the delay-word format
  function automatic longint mul_rnd(input longint c, input longint x);
    mul_rnd = rnd_shift(c * x, PROD_SHIFT);
  endfunction

  // Channel count as the block uses it: zero acts as one, large values clip
  function automatic int unsigned live_channels();
    if (chan_cfg == 0) live_channels = 1;
    else if (chan_cfg > NCH) live_channels = NCH;
    else live_channels = 32'(chan_cfg);
  endfunction

  function automatic void clear_lines();
    for (int i = 0; i < NCH; i++) begin
      dly_one[i] = 0;
      dly_two[i] = 0;
    end
    chan_ptr = 0;
  endfunction

  function automatic void reset_model();
    k_b0 = longint'($signed(COEF_ONE));
    k_b1 = 0;
    k_b2 = 0;
    k_a1 = 0;
    k_a2 = 0;
    chan_cfg = 1;
    clear_lines();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [COEF_BITS-1:0] val);
    case (idx)
      REG_B0: k_b0 = longint'($signed(val));
      REG_B1: k_b1 = longint'($signed(val));
      REG_B2: k_b2 = longint'($signed(val));
      REG_A1: k_a1 = longint'($signed(val));
      REG_A2: k_a2 = longint'($signed(val));
      REG_CHANNELS: begin
        chan_cfg = val[CH_CFG_BITS-1:0];
        clear_lines();
      end
      default: ;  // spare index: no effect
    endcase
  endfunction

  // Run one sample through the transposed section and queue its output
  function automatic void filter_sample(input logic [SBITS-1:0] smp, input logic last);
    longint      x, acc, y, z1, z2;
    int unsigned ch, n;
    filt_out_t   r;
    n  = live_channels();
    ch = chan_ptr;
    if (ch >= n) ch = 0;
    x   = longint'($signed(smp));
    acc = mul_rnd(k_b0, x) + dly_one[ch];
    y   = sat(rnd_shift(acc, OUT_SHIFT), SBITS);
    z1  = mul_rnd(k_b1, x) - mul_rnd(k_a1, y) + dly_two[ch];
    z2  = mul_rnd(k_b2, x) - mul_rnd(k_a2, y);
    dly_one[ch] = sat(z1, DELAY_BITS);
    dly_two[ch] = sat(z2, DELAY_BITS);
    chan_ptr = (ch + 1 >= n) ? 0 : ch + 1;
    r.sample = y[SBITS-1:0];
    r.chan   = ch[OUT_CH_BITS-1:0];
    r.last   = last;
    awaited_outputs.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random backpressure and the checker
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare every output transfer with the oldest awaited sample
  always @(posedge clk_i) begin : check_output
    filt_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sample = m_axis_tdata[SBITS-1:0];
      got.chan   = m_axis_tdata[SBITS +: OUT_CH_BITS];
      got.last   = m_axis_tlast;
      if (awaited_outputs.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("testbench: unexpected output sample %h ch %0d last %b",
                   got.sample, got.chan, got.last);
      end else begin
        want = awaited_outputs.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("testbench: mismatch: expected sample %h ch %0d last %b, got sample %h ch %0d last %b",
                     want.sample, want.chan, want.last, got.sample, got.chan, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Send one item on the sample stream; predict at the transfer edge.
  // Drop tvalid only when a gap is taken, so back-to-back items keep it high.
  task automatic send_item(input opcode_e op, input logic [SBITS-1:0] smp,
                           input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_CLEAR) clear_lines();
    else filter_sample(smp, last);
  endtask

  // Write one register once the block has gone idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    // A clear leaves no output behind, so hold off for a full sample time
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
      default: begin src_idle_pct = 34; snk_stall_pct = 34; end
    endcase
  endtask

  function automatic logic [SBITS-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0:       rand_sample = SMP_MAX;
      1:       rand_sample = SMP_MIN;
      2:       rand_sample = {{(SBITS-8){r[8]}}, r[7:0]};  // near zero
      default: rand_sample = r[SBITS-1:0];
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0:       rand_coef = r;                              // anywhere in Q3.28
      1:       rand_coef = $urandom_range(1) ? COEF_MAX : COEF_MIN;
      2:       rand_coef = $urandom_range(1) ? COEF_ONE : '0;
      default: rand_coef = {{5{r[27]}}, r[26:0]};          // within +-0.5, stable
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset coefficients pass the sample straight through on one channel
  task automatic test_default_passthrough();
    send_item(OP_FILTER, SMP_MAX, 1'b0);
    send_item(OP_FILTER, SMP_MIN, 1'b1);
    send_item(OP_FILTER, '0, 1'b0);
    send_item(OP_FILTER, 24'h000001, 1'b1);
    send_item(OP_FILTER, 24'hFFFFFF, 1'b0);
  endtask

  // Largest gains drive the output into both rails; heavy feedback
  // stresses the delay words
  task automatic test_output_saturation();
    write_reg(REG_B0, COEF_MAX);
    send_item(OP_FILTER, SMP_MAX, 1'b0);
    send_item(OP_FILTER, SMP_MIN, 1'b0);
    write_reg(REG_B0, COEF_MIN);
    send_item(OP_FILTER, SMP_MAX, 1'b1);
    send_item(OP_FILTER, SMP_MIN, 1'b0);
    write_reg(REG_B1, COEF_MAX);
    write_reg(REG_B2, COEF_MIN);
    write_reg(REG_A1, COEF_MIN);
    write_reg(REG_A2, COEF_MAX);
    send_item(OP_FILTER, SMP_MAX, 1'b0);
    send_item(OP_FILTER, SMP_MIN, 1'b1);
  endtask

  // Round-robin over channels, clear opcode, count of zero and above max
  task automatic test_channel_count_limits();
    write_reg(REG_B0, COEF_HALF);
    write_reg(REG_B1, COEF_HALF);
    write_reg(REG_B2, COEF_NEG_HALF);
    write_reg(REG_A1, COEF_NEG_HALF);
    write_reg(REG_A2, COEF_HALF);
    // Upper data bits set: only the low nibble counts, giving three channels
    write_reg(REG_CHANNELS, 32'hFFFF_FFF3);
    for (int i = 0; i < 4; i++) send_item(OP_FILTER, rand_sample(), i[0]);
    send_item(OP_CLEAR, SBITS'($urandom), 1'b1);
    send_item(OP_FILTER, SMP_MAX, 1'b0);
    send_item(OP_FILTER, SMP_MIN, 1'b0);
    write_reg(REG_CHANNELS, 32'd0);
    send_item(OP_FILTER, SMP_MAX, 1'b0);
    send_item(OP_FILTER, SMP_MAX, 1'b1);
    write_reg(REG_CHANNELS, 32'd15);
    send_item(OP_FILTER, SMP_MIN, 1'b0);
    send_item(OP_FILTER, SMP_MAX, 1'b0);
  endtask

  // Writes to the spare indexes must leave every register alone
  task automatic test_unknown_index();
    write_reg(IDX_SPARE_LO, $urandom);
    write_reg(IDX_SPARE_HI, $urandom);
    send_item(OP_FILTER, rand_sample(), 1'b1);
  endtask

  // Random phases: fresh coefficients and channel count per phase, mostly
  // filter items with occasional clears, idling rotating through all modes
  task automatic test_random_traffic(input int unsigned n_phases,
                                     input int unsigned per_phase);
    int unsigned nch;
    for (int p = 0; p < n_phases; p++) begin
      set_idling(p % 4);
      write_reg(REG_B0, rand_coef());
      write_reg(REG_B1, rand_coef());
      write_reg(REG_B2, rand_coef());
      write_reg(REG_A1, rand_coef());
      write_reg(REG_A2, rand_coef());
      if ($urandom_range(3) == 0) nch = $urandom_range(15);
      else nch = $urandom_range(NCH, 1);
      write_reg(REG_CHANNELS, nch);
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(7, 6)), $urandom);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(31) == 0)
          send_item(OP_CLEAR, SBITS'($urandom), 1'($urandom_range(1)));
        else
          send_item(OP_FILTER, rand_sample(), $urandom_range(7) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_passthrough();
    test_output_saturation();
    test_channel_count_limits();
    test_unknown_index();
    test_random_traffic(8, 132);

    // Drain: wait for every awaited output, then let the pipeline run dry
    s_axis_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(8_000_000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/mbq_pkg.sv
rtl/mbq_ram.sv
rtl/mbq_serial_mul.sv
rtl/multichannel_biquad_iir.sv
tb/sv/testbench.sv
